// ----- sv/itp_pkg.sv -----
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  typedef logic [2:0] code_t;

  localparam code_t CODE_LPAREN = 3'd0;
  localparam code_t CODE_PLUS   = 3'd1;
  localparam code_t CODE_MINUS  = 3'd2;
  localparam code_t CODE_MUL    = 3'd3;
  localparam code_t CODE_DIV    = 3'd4;
  localparam code_t CODE_POW    = 3'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_expression;
    status_t    status;
  } out_beat_t;

  function automatic logic [7:0] code_char(input code_t code);
    logic [7:0] ch;
    unique case (code)
      CODE_LPAREN: ch = CH_LPAREN;
      CODE_PLUS:   ch = CH_PLUS;
      CODE_MINUS:  ch = CH_MINUS;
      CODE_MUL:    ch = CH_STAR;
      CODE_DIV:    ch = CH_SLASH;
      CODE_POW:    ch = CH_CARET;
      default:     ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input code_t code);
    logic [1:0] p;
    unique case (code)
      CODE_PLUS, CODE_MINUS: p = 2'd1;
      CODE_MUL, CODE_DIV:    p = 2'd2;
      CODE_POW:              p = 2'd3;
      default:               p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
  endfunction

  // operator code, zero when the character is no binary operator
  function automatic code_t op_code(input logic [7:0] ch);
    code_t c;
    unique case (ch)
      CH_PLUS:  c = CODE_PLUS;
      CH_MINUS: c = CODE_MINUS;
      CH_STAR:  c = CODE_MUL;
      CH_SLASH: c = CODE_DIV;
      CH_CARET: c = CODE_POW;
      default:  c = CODE_LPAREN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/infix_to_postfix_converter.sv -----
// a letter's beat is registered into cur on acceptance, then written from S_WORK into the output register
// each input beat passes S_IDLE and S_WORK, and S_WORK repeats once per operator popped from the stack;
// a new beat is taken only back in S_IDLE; the last character then passes S_FRD and S_FLUSH; one stack access per cycle
// result stalls hold the sequencer, a finished beat waits in the output register
// reset clears the stack count, the discard flag, the sequencer and the output valid
// the operator stack memory is not initialized; only entries below the count are used
`default_nettype none

module infix_to_postfix_converter (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      src_valid,
  output logic                     src_ready,
  input  wire itp_pkg::in_beat_t   src_data,
  output logic                     res_valid,
  input  wire                      res_ready,
  output itp_pkg::out_beat_t       res_data
);
  import itp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WORK  = 4'b0010,
    S_FRD   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t              state, state_next;
  in_beat_t            cur;
  logic [COUNT_W-1:0]  count, count_next;
  logic                disc, disc_next;

  code_t               stack_mem [STACK_DEPTH];
  code_t               top_code;
  logic                rd_en, wr_en;
  logic [STACK_AW-1:0] rd_addr, wr_addr;
  code_t               wr_data;

  logic                emit_req, out_free, go;
  out_beat_t           emit_beat;

  code_t               cur_op;
  logic                stack_full, pop_op;
  logic [COUNT_W-1:0]  count_m1, count_m2;

  assign src_ready  = (state == S_IDLE);
  assign out_free   = !res_valid || res_ready;
  assign go         = !emit_req || out_free;
  assign cur_op     = op_code(cur.in_char);
  assign stack_full = (count >= COUNT_W'(STACK_DEPTH));
  assign count_m1   = count - COUNT_W'(1);
  assign count_m2   = count - COUNT_W'(2);
  assign pop_op     = (count != '0) && (top_code != CODE_LPAREN) &&
                      ((code_prec(top_code) > code_prec(cur_op)) ||
                       ((code_prec(top_code) == code_prec(cur_op)) && (cur_op != CODE_POW)));

  always_comb begin
    state_next = state;
    count_next = count;
    disc_next  = disc;
    emit_req   = 1'b0;
    emit_beat  = '{out_char: 8'd0, has_char: 1'b0, end_of_expression: 1'b0,
                   status: ST_OK};
    rd_en      = 1'b0;
    rd_addr    = count_m1[STACK_AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = count[STACK_AW-1:0];
    wr_data    = CODE_LPAREN;
    unique case (state)
      S_IDLE: begin
        if (src_valid) begin
          rd_en      = 1'b1;
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        state_next = cur.last_char ? S_FRD : S_IDLE;
        if (disc) begin
          state_next = S_IDLE;
          if (cur.last_char) begin
            emit_req  = 1'b1;
            emit_beat.end_of_expression = 1'b1;
            count_next = '0;
            disc_next  = 1'b0;
          end
        end else if (is_letter(cur.in_char)) begin
          emit_req           = 1'b1;
          emit_beat.out_char = cur.in_char;
          emit_beat.has_char = 1'b1;
        end else if (cur.in_char == CH_LPAREN) begin
          if (stack_full) begin
            emit_req         = 1'b1;
            emit_beat.status = ST_OVERFLOW;
          end else begin
            wr_en      = 1'b1;
            wr_data    = CODE_LPAREN;
            count_next = count + COUNT_W'(1);
          end
        end else if (cur.in_char == CH_RPAREN) begin
          if (count == '0) begin
            emit_req         = 1'b1;
            emit_beat.status = ST_UNMATCHED;
          end else if (top_code == CODE_LPAREN) begin
            count_next = count_m1;
          end else begin
            emit_req           = 1'b1;
            emit_beat.out_char = code_char(top_code);
            emit_beat.has_char = 1'b1;
            count_next         = count_m1;
            rd_en              = 1'b1;
            rd_addr            = count_m2[STACK_AW-1:0];
            state_next         = S_WORK;
          end
        end else if (cur_op != CODE_LPAREN) begin
          if (pop_op) begin
            emit_req           = 1'b1;
            emit_beat.out_char = code_char(top_code);
            emit_beat.has_char = 1'b1;
            count_next         = count_m1;
            rd_en              = 1'b1;
            rd_addr            = count_m2[STACK_AW-1:0];
            state_next         = S_WORK;
          end else if (stack_full) begin
            emit_req         = 1'b1;
            emit_beat.status = ST_OVERFLOW;
          end else begin
            wr_en      = 1'b1;
            wr_data    = cur_op;
            count_next = count + COUNT_W'(1);
          end
        end else begin
          emit_req         = 1'b1;
          emit_beat.status = ST_INVALID;
        end
        // error beat ends the expression's normal processing
        if (!disc && emit_req && !emit_beat.has_char) begin
          emit_beat.end_of_expression = cur.last_char;
          count_next = '0;
          disc_next  = !cur.last_char;
          state_next = S_IDLE;
        end
      end
      S_FRD: begin
        rd_en      = 1'b1;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        emit_req = 1'b1;
        if (count != '0) begin
          emit_beat.out_char = code_char(top_code);
          emit_beat.has_char = 1'b1;
          count_next         = count_m1;
          rd_en              = 1'b1;
          rd_addr            = count_m2[STACK_AW-1:0];
        end else begin
          emit_beat.end_of_expression = 1'b1;
          disc_next  = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      disc      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (go) begin
        state <= state_next;
        count <= count_next;
        disc  <= disc_next;
      end
      if (go && emit_req) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      cur <= src_data;
    end
    if (go && emit_req) begin
      res_data <= emit_beat;
    end
  end

  // operator stack, one write and one registered read port
  always_ff @(posedge clk) begin
    if (go && wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (go && rd_en) begin
      top_code <= stack_mem[rd_addr];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    go && emit_req && emit_beat.end_of_expression |=> (count == '0) && !disc)
    else $error("state not cleared after end of expression");

  a_flush_no_disc: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) || (state == S_FRD) |-> !disc)
    else $error("flush while discarding");

  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.has_char |-> (res_data.status == ST_OK) &&
                                       !res_data.end_of_expression)
    else $error("character beat with status or end mark");

endmodule

`default_nettype wire
